// ===== rtl/core/ust_pkg.sv =====
// shared types and constants for the universe sequence table
`timescale 1ns / 1ps

package ust_pkg;

  localparam int UNIVERSE_W    = 16;
  localparam int SEQ_W         = 8;
  localparam int ENTRY_COUNT_W = 10;
  localparam int MCAST_W       = 32;

  // 239.255.x.x prefix and byte masks of the universe number
  localparam logic [15:0] MCAST_PREFIX   = 16'hEFFF;
  localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;
  localparam logic [15:0] LOW_BYTE_MASK  = 16'h00FF;

  // one stored table entry
  typedef struct packed {
    logic [UNIVERSE_W-1:0] universe;
    logic [SEQ_W-1:0]      seq;
  } entry_t;

  // result handed from the lookup engine to the output stage
  typedef struct packed {
    logic [UNIVERSE_W-1:0]    universe;
    logic [SEQ_W-1:0]         seq_num;
    logic                     newly_added;
    logic                     table_full;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } result_t;

endpackage

// ===== rtl/core/universe_sequence_table.sv =====
// universe sequence table: top level with output register
//
// in channel: one beat carries a universe number; in_valid/in_ready.
// out channel: one beat per input beat with the sequence number, the
// 239.255.high.low multicast address, the newly_added and table_full flags
// and the entry count after the item; out_valid/out_ready.
//
// one item is worked at a time. the table sits in a single-port-read,
// single-port-write memory; the binary search does one memory read and
// compare per cycle. a lookup runs through accept, the halving search, the
// final compare and the hand-off to the output register. an insert that
// moves k larger entries up adds one read and one write per moved entry.
//
// reset clears the entry count; the table memory needs no clearing pass
// since only entries below the count are read. a stalled receiver holds the
// result in the output register; the next item is still accepted and
// searched, and waits at the end for the register to free up.
`timescale 1ns / 1ps

module universe_sequence_table #(
  parameter int MAX_ENTRIES = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ust_pkg::UNIVERSE_W-1:0]    universe,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ust_pkg::SEQ_W-1:0]         seq_num,
  output logic [ust_pkg::MCAST_W-1:0]       multicast_ip,
  output logic                              newly_added,
  output logic                              table_full,
  output logic [ust_pkg::ENTRY_COUNT_W-1:0] entry_count
);
  import ust_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;

  ust_engine #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .universe  (universe),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, loads when empty or drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      seq_num      <= res.seq_num;
      multicast_ip <= {MCAST_PREFIX,
                       (res.universe & HIGH_BYTE_MASK) | (res.universe & LOW_BYTE_MASK)};
      newly_added  <= res.newly_added;
      table_full   <= res.table_full;
      entry_count  <= res.entry_count;
    end
  end

endmodule

// ===== rtl/core/ust_engine.sv =====
// sorted table memory with binary search, counter update and shifting insert
`timescale 1ns / 1ps

module ust_engine #(
  parameter int MAX_ENTRIES = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ust_pkg::UNIVERSE_W-1:0] universe,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ust_pkg::result_t               res
);
  import ust_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_SH_RD  = 3'd3;
  localparam logic [2:0] ST_SH_WR  = 3'd4;
  localparam logic [2:0] ST_INSERT = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]            state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         lo, lo_next;
  logic [CW-1:0]         hi, hi_next;
  logic [CW-1:0]         wr_ptr, wr_ptr_next;
  logic [UNIVERSE_W-1:0] univ, univ_next;
  logic [SEQ_W-1:0]      res_seq, res_seq_next;
  logic                  res_added, res_added_next;
  logic                  res_full, res_full_next;

  // table memory, one read and one write port
  entry_t                mem [MAX_ENTRIES];
  entry_t                rdata;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         waddr;
  entry_t                wdata;

  // search step values
  logic [CW-1:0]         mid;
  logic [CW-1:0]         mid_plus;
  logic                  below;
  logic [CW-1:0]         lo_s;
  logic [CW-1:0]         hi_s;
  logic [CW-1:0]         mid_s;
  logic                  hit;
  logic [CW-1:0]         wr_ptr_dec;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // one halving step per cycle: compare the entry read at mid, pick next bounds
  assign mid      = lo + ((hi - lo) >> 1);
  assign mid_plus = mid + CW'(1);
  assign below    = rdata.universe < univ;
  assign lo_s     = below ? mid_plus : lo;
  assign hi_s     = below ? hi : mid;
  assign mid_s    = lo_s + ((hi_s - lo_s) >> 1);
  assign hit      = (lo < count) && (rdata.universe == univ);
  assign wr_ptr_dec = wr_ptr - CW'(1);

  // sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    wr_ptr_next    = wr_ptr;
    univ_next      = univ;
    res_seq_next   = res_seq;
    res_added_next = res_added;
    res_full_next  = res_full;
    rd_en          = 1'b0;
    rd_addr        = mid_s[AW-1:0];
    we             = 1'b0;
    waddr          = lo[AW-1:0];
    wdata          = rdata;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          univ_next = universe;
          lo_next   = '0;
          hi_next   = count;
          if (count != '0) begin
            rd_en      = 1'b1;
            rd_addr    = AW'(count >> 1);
            state_next = ST_SEARCH;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_SEARCH: begin
        lo_next = lo_s;
        hi_next = hi_s;
        if (lo_s < hi_s) begin
          rd_en   = 1'b1;
          rd_addr = mid_s[AW-1:0];
        end else begin
          // fetch the lower-bound entry for the final compare
          rd_en      = lo_s < count;
          rd_addr    = lo_s[AW-1:0];
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (hit) begin
          we             = 1'b1;
          waddr          = lo[AW-1:0];
          wdata.universe = univ;
          wdata.seq      = rdata.seq + SEQ_W'(1);
          res_seq_next   = rdata.seq + SEQ_W'(1);
          res_added_next = 1'b0;
          res_full_next  = 1'b0;
          state_next     = ST_DONE;
        end else if (count >= MAX_CNT) begin
          res_seq_next   = '0;
          res_added_next = 1'b0;
          res_full_next  = 1'b1;
          state_next     = ST_DONE;
        end else if (lo == count) begin
          state_next = ST_INSERT;
        end else begin
          wr_ptr_next = count;
          state_next  = ST_SH_RD;
        end
      end
      ST_SH_RD: begin
        rd_en      = 1'b1;
        rd_addr    = wr_ptr_dec[AW-1:0];
        state_next = ST_SH_WR;
      end
      ST_SH_WR: begin
        // move one entry up by one place
        we          = 1'b1;
        waddr       = wr_ptr[AW-1:0];
        wdata       = rdata;
        wr_ptr_next = wr_ptr_dec;
        state_next  = (wr_ptr_dec == lo) ? ST_INSERT : ST_SH_RD;
      end
      ST_INSERT: begin
        we             = 1'b1;
        waddr          = lo[AW-1:0];
        wdata.universe = univ;
        wdata.seq      = '0;
        count_next     = count + CW'(1);
        res_seq_next   = '0;
        res_added_next = 1'b1;
        res_full_next  = 1'b0;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    lo        <= lo_next;
    hi        <= hi_next;
    wr_ptr    <= wr_ptr_next;
    univ      <= univ_next;
    res_seq   <= res_seq_next;
    res_added <= res_added_next;
    res_full  <= res_full_next;
  end

  assign in_ready  = state == ST_IDLE;
  assign res_valid = state == ST_DONE;

  always_comb begin
    res.universe    = univ;
    res.seq_num     = res_seq;
    res.newly_added = res_added;
    res.table_full  = res_full;
    res.entry_count = ENTRY_COUNT_W'(count);
  end

  // count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("entry count above table size");

  // search bounds stay ordered and inside the filled part
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> (lo < hi) && (hi <= count))
    else $error("search bounds out of order");

  // count grows by one exactly after an insert and is otherwise held
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && state != ST_INSERT |=> $stable(count))
    else $error("entry count changed outside insert");

  // a full-table miss never writes the table
  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK && !hit && count >= MAX_CNT |-> !we)
    else $error("table written on full miss");

endmodule
